// ----- src/qspi_pkg.sv -----
// shared constants, control struct and spline weight tables for the point interpolator
package qspi_pkg;

	localparam int SAMPLES    = 11;
	localparam int IDX_W      = 4;
	localparam int WEIGHT_W   = 16;
	localparam int FRAC_SHIFT = 16;
	localparam int ROUND_HALF = 32768;

	// sample index of the final result in each run kind
	localparam logic [IDX_W-1:0] IDX_PASS_LAST = IDX_W'(1);
	localparam logic [IDX_W-1:0] IDX_SPL_LAST  = IDX_W'(SAMPLES - 1);

	// stroke history fill level
	localparam logic [1:0] SEEN_NONE = 2'd0;
	localparam logic [1:0] SEEN_ONE  = 2'd1;
	localparam logic [1:0] SEEN_MORE = 2'd2;

	typedef struct packed {
		logic             pass;
		logic [IDX_W-1:0] idx;
		logic             last;
	} samp_ctl_t;

	// weight of the oldest point, 0.5(1-t)^2 in Q0.16
	function automatic logic [WEIGHT_W-1:0] wt_old(input logic [IDX_W-1:0] k);
		logic [WEIGHT_W-1:0] w;
		case (k)
			4'd0:    w = 16'd32768;
			4'd1:    w = 16'd26542;
			4'd2:    w = 16'd20972;
			4'd3:    w = 16'd16056;
			4'd4:    w = 16'd11796;
			4'd5:    w = 16'd8192;
			4'd6:    w = 16'd5243;
			4'd7:    w = 16'd2949;
			4'd8:    w = 16'd1311;
			4'd9:    w = 16'd328;
			default: w = 16'd0;
		endcase
		return w;
	endfunction

	// weight of the middle point, 0.5+t-t^2 in Q0.16
	function automatic logic [WEIGHT_W-1:0] wt_mid(input logic [IDX_W-1:0] k);
		logic [WEIGHT_W-1:0] w;
		case (k)
			4'd0:    w = 16'd32768;
			4'd1:    w = 16'd38666;
			4'd2:    w = 16'd43254;
			4'd3:    w = 16'd46531;
			4'd4:    w = 16'd48497;
			4'd5:    w = 16'd49152;
			4'd6:    w = 16'd48497;
			4'd7:    w = 16'd46531;
			4'd8:    w = 16'd43254;
			4'd9:    w = 16'd38666;
			4'd10:   w = 16'd32768;
			default: w = 16'd0;
		endcase
		return w;
	endfunction

	// weight of the newest point, 0.5t^2 in Q0.16
	function automatic logic [WEIGHT_W-1:0] wt_new(input logic [IDX_W-1:0] k);
		logic [WEIGHT_W-1:0] w;
		case (k)
			4'd0:    w = 16'd0;
			4'd1:    w = 16'd328;
			4'd2:    w = 16'd1311;
			4'd3:    w = 16'd2949;
			4'd4:    w = 16'd5243;
			4'd5:    w = 16'd8192;
			4'd6:    w = 16'd11796;
			4'd7:    w = 16'd16056;
			4'd8:    w = 16'd20972;
			4'd9:    w = 16'd26542;
			4'd10:   w = 16'd32768;
			default: w = 16'd0;
		endcase
		return w;
	endfunction

endpackage

// ----- src/qspi_in_if.sv -----
// input point channel: valid/ready handshake with stroke point payload
interface qspi_in_if #(
	parameter int COORD_BITS = 16
) ();
	logic                  valid;
	logic                  ready;
	logic                  stroke_start;
	logic [COORD_BITS-1:0] x_coord;
	logic [COORD_BITS-1:0] y_coord;

	modport source (output valid, stroke_start, x_coord, y_coord, input ready);
	modport sink (input valid, stroke_start, x_coord, y_coord, output ready);
endinterface

// ----- src/qspi_out_if.sv -----
// output sample channel: valid/ready handshake with interpolated sample payload
interface qspi_out_if #(
	parameter int COORD_BITS = 16
) ();
	logic                        valid;
	logic                        ready;
	logic [COORD_BITS-1:0]       out_x;
	logic [COORD_BITS-1:0]       out_y;
	logic [qspi_pkg::IDX_W-1:0]  sample_index;
	logic                        is_last;

	modport source (output valid, out_x, out_y, sample_index, is_last, input ready);
	modport sink (input valid, out_x, out_y, sample_index, is_last, output ready);
endinterface

// ----- src/qspi_seq.sv -----
// point history and per-point sample sequencer
module qspi_seq #(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	qspi_in_if.sink               points,
	output logic                  samp_valid,
	input  logic                  samp_take,
	output qspi_pkg::samp_ctl_t   samp_ctl,
	output logic [COORD_BITS-1:0] p0_x,
	output logic [COORD_BITS-1:0] p0_y,
	output logic [COORD_BITS-1:0] p1_x,
	output logic [COORD_BITS-1:0] p1_y,
	output logic [COORD_BITS-1:0] p2_x,
	output logic [COORD_BITS-1:0] p2_y
);
	import qspi_pkg::*;

	logic [COORD_BITS-1:0] older_x_q, older_y_q, newer_x_q, newer_y_q;
	logic [COORD_BITS-1:0] p0_x_q, p0_y_q, p1_x_q, p1_y_q, p2_x_q, p2_y_q;
	logic [1:0]            seen_q;
	logic                  busy_q;
	logic                  pass_q;
	logic [IDX_W-1:0]      k_q;

	logic acc, fresh, emit, last, start_run;

	always_comb begin
		last          = pass_q ? (k_q == IDX_PASS_LAST) : (k_q == IDX_SPL_LAST);
		emit          = busy_q & samp_take;
		points.ready  = ~busy_q | (emit & last);
		acc           = points.valid & points.ready;
		fresh         = points.stroke_start | (seen_q == SEEN_NONE);
		start_run     = acc & ~fresh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_x_q <= '0;
			older_y_q <= '0;
			newer_x_q <= '0;
			newer_y_q <= '0;
			seen_q    <= SEEN_NONE;
			busy_q    <= 1'b0;
			pass_q    <= 1'b0;
			k_q       <= '0;
		end else begin
			// a new run may begin in the cycle that ends the current one
			if (start_run) begin
				busy_q <= 1'b1;
			end else if (emit && last) begin
				busy_q <= 1'b0;
			end
			if (emit && !last) begin
				k_q <= k_q + IDX_W'(1);
			end else if (start_run) begin
				k_q <= '0;
			end
			if (acc) begin
				if (fresh) begin
					older_x_q <= points.x_coord;
					older_y_q <= points.y_coord;
					newer_x_q <= points.x_coord;
					newer_y_q <= points.y_coord;
					seen_q    <= SEEN_ONE;
				end else begin
					older_x_q <= newer_x_q;
					older_y_q <= newer_y_q;
					newer_x_q <= points.x_coord;
					newer_y_q <= points.y_coord;
					seen_q    <= SEEN_MORE;
					pass_q    <= (seen_q == SEEN_ONE);
				end
			end
		end
	end

	// run operands, loaded with the transaction that starts a run
	always_ff @(posedge clk) begin
		if (start_run) begin
			p0_x_q <= older_x_q;
			p0_y_q <= older_y_q;
			p1_x_q <= newer_x_q;
			p1_y_q <= newer_y_q;
			p2_x_q <= points.x_coord;
			p2_y_q <= points.y_coord;
		end
	end

	assign samp_valid = busy_q;
	assign samp_ctl   = '{pass: pass_q, idx: k_q, last: last};
	assign p0_x = p0_x_q;
	assign p0_y = p0_y_q;
	assign p1_x = p1_x_q;
	assign p1_y = p1_y_q;
	assign p2_x = p2_x_q;
	assign p2_y = p2_y_q;

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (k_q <= IDX_SPL_LAST))
		else $error("sample counter out of range");
	a_pass_range: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && pass_q) |-> (k_q <= IDX_PASS_LAST))
		else $error("pass-through run longer than two samples");
	a_fresh_stores: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && fresh) |=> (seen_q == SEEN_ONE))
		else $error("stroke start did not reset history");
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last && !(acc && !fresh)) |=> !busy_q)
		else $error("run did not end after its last sample");
`endif

endmodule

// ----- src/qspi_blend.sv -----
// two-stage spline blend: weighted products, then sum, round and saturate, or pass-through
module qspi_blend #(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  samp_valid,
	output logic                  samp_take,
	input  qspi_pkg::samp_ctl_t   samp_ctl,
	input  logic [COORD_BITS-1:0] p0_x,
	input  logic [COORD_BITS-1:0] p0_y,
	input  logic [COORD_BITS-1:0] p1_x,
	input  logic [COORD_BITS-1:0] p1_y,
	input  logic [COORD_BITS-1:0] p2_x,
	input  logic [COORD_BITS-1:0] p2_y,
	qspi_out_if.source            samples
);
	import qspi_pkg::*;

	localparam int PW = COORD_BITS + WEIGHT_W;
	localparam int SW = PW + 2;
	localparam int RW = SW - FRAC_SHIFT;

	logic                  v_s1, v_s2;
	samp_ctl_t             ctl_s1;
	logic [PW-1:0]         pox_s1, pmx_s1, pnx_s1, poy_s1, pmy_s1, pny_s1;
	logic [COORD_BITS-1:0] pass_x_s1, pass_y_s1;
	logic [COORD_BITS-1:0] x_s2, y_s2;
	logic [IDX_W-1:0]      idx_s2;
	logic                  last_s2;

	logic [WEIGHT_W-1:0]   w_o, w_m, w_n;
	logic                  adv2;
	logic [COORD_BITS-1:0] bx, by;

	function automatic logic [COORD_BITS-1:0] sum_round(
		input logic [PW-1:0] a,
		input logic [PW-1:0] b,
		input logic [PW-1:0] c
	);
		logic [SW-1:0] s;
		logic [RW-1:0] r;
		s = SW'(a) + SW'(b) + SW'(c) + SW'(ROUND_HALF);
		r = s[SW-1:FRAC_SHIFT];
		if (|r[RW-1:COORD_BITS]) begin
			return '1;
		end
		return r[COORD_BITS-1:0];
	endfunction

	always_comb begin
		w_o       = wt_old(samp_ctl.idx);
		w_m       = wt_mid(samp_ctl.idx);
		w_n       = wt_new(samp_ctl.idx);
		adv2      = ~v_s2 | samples.ready;
		samp_take = ~v_s1 | adv2;
		bx        = sum_round(pox_s1, pmx_s1, pnx_s1);
		by        = sum_round(poy_s1, pmy_s1, pny_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (samp_take) begin
				v_s1 <= samp_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (samp_take && samp_valid) begin
			ctl_s1    <= samp_ctl;
			pox_s1    <= PW'(w_o) * PW'(p0_x);
			pmx_s1    <= PW'(w_m) * PW'(p1_x);
			pnx_s1    <= PW'(w_n) * PW'(p2_x);
			poy_s1    <= PW'(w_o) * PW'(p0_y);
			pmy_s1    <= PW'(w_m) * PW'(p1_y);
			pny_s1    <= PW'(w_n) * PW'(p2_y);
			pass_x_s1 <= (samp_ctl.idx == '0) ? p1_x : p2_x;
			pass_y_s1 <= (samp_ctl.idx == '0) ? p1_y : p2_y;
		end
		if (adv2 && v_s1) begin
			x_s2    <= ctl_s1.pass ? pass_x_s1 : bx;
			y_s2    <= ctl_s1.pass ? pass_y_s1 : by;
			idx_s2  <= ctl_s1.idx;
			last_s2 <= ctl_s1.last;
		end
	end

	assign samples.valid        = v_s2;
	assign samples.out_x        = x_s2;
	assign samples.out_y        = y_s2;
	assign samples.sample_index = idx_s2;
	assign samples.is_last      = last_s2;

`ifndef SYNTHESIS
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv2) |=> v_s1)
		else $error("product stage dropped a sample under stall");
`endif

endmodule

// ----- src/quadratic_spline_point_interpolator_top.sv -----
// top level of the quadratic spline point interpolator
//
//  channel   dir  payload                                   handshake
//  points    in   stroke_start, x_coord, y_coord            valid/ready
//  samples   out  out_x, out_y, sample_index, is_last       valid/ready
//
// a point transaction causes 0, 2 or 11 sample transactions; the sequencer
// puts out one sample per cycle unless the blend pipeline stalls, stepped by
// the sample counter in qspi_seq
// the next point is taken in the same cycle as the last sample of a run
// the first sample of a point is offered once it has passed the product and sum stages
// reset clears the stroke history and all valid flags; no clearing pass
// a stalled samples channel backs up through both stages to points.ready
module quadratic_spline_point_interpolator_top #(
	parameter int COORD_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	qspi_in_if.sink      points,
	qspi_out_if.source   samples
);
	import qspi_pkg::*;

	// sequencer to blend pipeline
	logic                  samp_valid;
	logic                  samp_take;
	samp_ctl_t             samp_ctl;
	logic [COORD_BITS-1:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y;

	// history, run start and per-sample stepping
	qspi_seq #(
		.COORD_BITS (COORD_BITS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.points     (points),
		.samp_valid (samp_valid),
		.samp_take  (samp_take),
		.samp_ctl   (samp_ctl),
		.p0_x       (p0_x),
		.p0_y       (p0_y),
		.p1_x       (p1_x),
		.p1_y       (p1_y),
		.p2_x       (p2_x),
		.p2_y       (p2_y)
	);

	// weighted sum with rounding and saturation, or pass-through
	qspi_blend #(
		.COORD_BITS (COORD_BITS)
	) u_blend (
		.clk        (clk),
		.arst_n     (arst_n),
		.samp_valid (samp_valid),
		.samp_take  (samp_take),
		.samp_ctl   (samp_ctl),
		.p0_x       (p0_x),
		.p0_y       (p0_y),
		.p1_x       (p1_x),
		.p1_y       (p1_y),
		.p2_x       (p2_x),
		.p2_y       (p2_y),
		.samples    (samples)
	);

endmodule

// ----- tb/sv/tb_quadratic_spline_point_interpolator_top.sv -----
// testbench for the quadratic spline point interpolator: directed and random strokes under stalls
module tb_quadratic_spline_point_interpolator_top;
	import qspi_pkg::*;

	localparam int COORD_BITS = 16;
	// t runs over 0 .. STEPS tenths
	localparam int STEPS = SAMPLES - 1;
	localparam logic [COORD_BITS-1:0] COORD_TOP = '1;
	// limit above the slowest legal run, up to 11 samples per point under stalls
	localparam int unsigned CYCLE_LIMIT = 400000;
	// leave room after the drain for a stray sample to show up through the pipeline
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_ITEMS = 50;

	// one expected or observed sample transaction
	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [IDX_W-1:0]      idx;
		logic                  last;
	} sample_t;

	// tracks the stroke history and holds the samples still owed by the block
	class spline_scoreboard;
		sample_t               owed[$];
		logic [COORD_BITS-1:0] back_x, back_y;
		logic [COORD_BITS-1:0] head_x, head_y;
		logic [1:0]            fill;
		int unsigned           fails;

		function new();
			back_x = '0;
			back_y = '0;
			head_x = '0;
			head_y = '0;
			fill   = SEEN_NONE;
			fails  = 0;
		endfunction

		// Q0.16 weights rounded to nearest from 0.5(1-t)^2, 0.5+t-t^2 and 0.5t^2
		function longint unsigned weight_back(int k);
			return longint'(((STEPS - k) * (STEPS - k) * 32768 + STEPS * STEPS / 2)
				/ (STEPS * STEPS));
		endfunction

		function longint unsigned weight_mid(int k);
			return longint'(((STEPS * STEPS / 2 + STEPS * k - k * k) * 65536
				+ STEPS * STEPS / 2) / (STEPS * STEPS));
		endfunction

		function longint unsigned weight_new(int k);
			return longint'((k * k * 32768 + STEPS * STEPS / 2) / (STEPS * STEPS));
		endfunction

		function logic [COORD_BITS-1:0] blend(int k, logic [COORD_BITS-1:0] a,
				logic [COORD_BITS-1:0] b, logic [COORD_BITS-1:0] c);
			longint unsigned acc;
			acc = weight_back(k) * 64'(a) + weight_mid(k) * 64'(b) + weight_new(k) * 64'(c);
			acc = (acc + 64'(ROUND_HALF)) >> FRAC_SHIFT;
			// the t = 0.2 and t = 0.8 weights sum past one, so clip
			if (acc > 64'(COORD_TOP))
				acc = 64'(COORD_TOP);
			return acc[COORD_BITS-1:0];
		endfunction

		function void note_point(logic start, logic [COORD_BITS-1:0] cx,
				logic [COORD_BITS-1:0] cy);
			sample_t s;
			// a stroke start, or a point with no open stroke, only refills the history
			if (start || fill == SEEN_NONE) begin
				back_x = cx;
				back_y = cy;
				head_x = cx;
				head_y = cy;
				fill   = SEEN_ONE;
				return;
			end
			if (fill == SEEN_ONE) begin
				// second point of a stroke passes both points through
				s.x    = head_x;
				s.y    = head_y;
				s.idx  = '0;
				s.last = 1'b0;
				owed.push_back(s);
				s.x    = cx;
				s.y    = cy;
				s.idx  = IDX_PASS_LAST;
				s.last = 1'b1;
				owed.push_back(s);
			end else begin
				// counter value three cannot occur and would act like two
				for (int k = 0; k < SAMPLES; k++) begin
					s.x    = blend(k, back_x, head_x, cx);
					s.y    = blend(k, back_y, head_y, cy);
					s.idx  = IDX_W'(k);
					s.last = (k == STEPS);
					owed.push_back(s);
				end
			end
			back_x = head_x;
			back_y = head_y;
			head_x = cx;
			head_y = cy;
			fill   = SEEN_MORE;
		endfunction

		function void check_sample(sample_t got);
			sample_t want;
			if (owed.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected sample: x=%0d y=%0d idx=%0d last=%0d",
						got.x, got.y, got.idx, got.last);
				return;
			end
			want = owed.pop_front();
			if (got.x !== want.x || got.y !== want.y || got.idx !== want.idx
					|| got.last !== want.last) begin
				fails++;
				if (fails <= 10)
					$display("sample mismatch: expected x=%0d y=%0d idx=%0d last=%0d,",
						want.x, want.y, want.idx, want.last,
						" got x=%0d y=%0d idx=%0d last=%0d",
						got.x, got.y, got.idx, got.last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	qspi_in_if  #(.COORD_BITS(COORD_BITS)) point_bus ();
	qspi_out_if #(.COORD_BITS(COORD_BITS)) sample_bus ();

	quadratic_spline_point_interpolator_top #(
		.COORD_BITS(COORD_BITS)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.points  (point_bus),
		.samples (sample_bus)
	);

	spline_scoreboard sb = new();

	// chance per cycle that the sender holds off, and that the receiver stalls
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// watchdog: a hung handshake or a lost sample ends here
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAIL quadratic_spline_point_interpolator_top");
		$finish;
	end

	// both channels are observed at the rising edge, with values settled since the falling edge
	always @(posedge clk) begin
		sample_t got;
		if (arst_n) begin
			if (point_bus.valid && point_bus.ready)
				sb.note_point(point_bus.stroke_start, point_bus.x_coord, point_bus.y_coord);
			if (sample_bus.valid && sample_bus.ready) begin
				got.x    = sample_bus.out_x;
				got.y    = sample_bus.out_y;
				got.idx  = sample_bus.sample_index;
				got.last = sample_bus.is_last;
				sb.check_sample(got);
			end
		end
	end

	// receiver: ready is redrawn on each falling edge, held low during reset
	initial begin
		sample_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			sample_bus.ready = arst_n && ($urandom_range(99) >= stall_pct);
		end
	end

	// one point transaction: optional hold-off, then wait for the accepting edge
	task automatic push_point(input logic start, input logic [COORD_BITS-1:0] px,
			input logic [COORD_BITS-1:0] py);
		while ($urandom_range(99) < idle_pct) begin
			point_bus.valid = 1'b0;
			@(negedge clk);
		end
		point_bus.valid        = 1'b1;
		point_bus.stroke_start = start;
		point_bus.x_coord      = px;
		point_bus.y_coord      = py;
		do
			@(posedge clk);
		while (!point_bus.ready);
		@(negedge clk);
	endtask

	// next point of a stroke: mostly a short step, sometimes a jump or an edge of the board
	function automatic logic [COORD_BITS-1:0] step_coord(logic [COORD_BITS-1:0] prev);
		int pick;
		int v;
		pick = int'($urandom_range(99));
		if (pick < 10)
			return $urandom_range(1) ? COORD_TOP : '0;
		if (pick < 35)
			return COORD_BITS'($urandom);
		v = int'(prev) + int'($urandom_range(4000)) - 2000;
		if (v < 0)
			v = 0;
		if (v > int'(COORD_TOP))
			v = int'(COORD_TOP);
		return COORD_BITS'(v);
	endfunction

	task automatic run_directed();
		// a point right after reset with no stroke open only opens one
		push_point(1'b0, 16'd1234, 16'd4321);
		// second point passes through, third gives a full spline run
		push_point(1'b0, COORD_TOP, 16'd0);
		push_point(1'b0, 16'd0, COORD_TOP);
		// all points at the top corner: the t = 0.2 and t = 0.8 sums clip
		push_point(1'b1, COORD_TOP, COORD_TOP);
		push_point(1'b0, COORD_TOP, COORD_TOP);
		push_point(1'b0, COORD_TOP, COORD_TOP);
		push_point(1'b0, COORD_TOP, COORD_TOP);
		// the zero corner
		push_point(1'b1, 16'd0, 16'd0);
		push_point(1'b0, 16'd0, 16'd0);
		push_point(1'b0, 16'd0, 16'd0);
		// zigzag between the extremes
		push_point(1'b1, 16'd0, COORD_TOP);
		push_point(1'b0, COORD_TOP, 16'd0);
		push_point(1'b0, 16'd0, COORD_TOP);
		push_point(1'b0, COORD_TOP, 16'd0);
		// back-to-back stroke starts, then a restart in the middle of a stroke
		push_point(1'b1, 16'd32768, 16'd32768);
		push_point(1'b1, 16'd100, 16'd200);
		push_point(1'b0, 16'd300, 16'd400);
		push_point(1'b0, 16'd500, 16'd600);
		push_point(1'b1, 16'd7, 16'd9);
		push_point(1'b0, 16'hAAAA, 16'h5555);
		push_point(1'b0, 16'h5555, 16'hAAAA);
		push_point(1'b0, 16'd65534, 16'd1);
		push_point(1'b0, 16'd43690, 16'd21845);
	endtask

	// mostly well-formed strokes with random content, some stray single points
	task automatic run_random(input int quota);
		int sent;
		int len;
		logic [COORD_BITS-1:0] px, py;
		sent = 0;
		while (sent < quota) begin
			if ($urandom_range(99) < 85) begin
				len = int'($urandom_range(8, 2));
				px  = COORD_BITS'($urandom);
				py  = COORD_BITS'($urandom);
				push_point(1'b1, px, py);
				sent++;
				for (int i = 1; i < len; i++) begin
					px = step_coord(px);
					py = step_coord(py);
					push_point(1'b0, px, py);
					sent++;
				end
			end else begin
				push_point(1'($urandom_range(1)), COORD_BITS'($urandom), COORD_BITS'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		point_bus.valid        = 1'b0;
		point_bus.stroke_start = 1'b0;
		point_bus.x_coord      = '0;
		point_bus.y_coord      = '0;
		arst_n                 = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();

		// no idling, then a lazy sender, then a stalling receiver, then light idling on both
		idle_pct  = 0;
		stall_pct = 0;
		run_random(PHASE_ITEMS);
		idle_pct  = 78;
		stall_pct = 0;
		run_random(PHASE_ITEMS);
		idle_pct  = 0;
		stall_pct = 78;
		run_random(PHASE_ITEMS);
		idle_pct  = 10;
		stall_pct = 10;
		run_random(PHASE_ITEMS);
		point_bus.valid = 1'b0;

		// drain what is owed, then give a stray transaction time to appear
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.fails == 0 && sb.owed.size() == 0)
			$display("PASS quadratic_spline_point_interpolator_top");
		else
			$display("FAIL quadratic_spline_point_interpolator_top");
		$finish;
	end

endmodule
